### sv/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg: shared types and constants of the palindromic tree builder
// Input and result item structs and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

	localparam int unsigned LetterW = 5;
	localparam int unsigned CountW  = 11;
	localparam int unsigned TotalW  = 20;

	typedef struct packed {
		logic [LetterW-1:0] letter;
		logic               restart;
	} in_item_t;

	typedef struct packed {
		logic [CountW-1:0] suffix_pal_count;
		logic [CountW-1:0] longest_suffix_len;
		logic [CountW-1:0] distinct_count;
		logic [TotalW-1:0] total_count;
		logic              is_new;
		logic              overflow;
	} out_item_t;

endpackage

`default_nettype wire

### sv/ptb_ram.sv
// ----------------------------------------------------------------------------
// ptb_ram: simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/palindromic_tree_builder_unit.sv
// ----------------------------------------------------------------------------
// palindromic_tree_builder_unit: eertree builder, one letter per item
// Sequencer around node, child and letter memories.
// ----------------------------------------------------------------------------
// Each item appends one letter and walks suffix links to the longest
// palindromic suffix it extends. Every link step reads the node memory,
// then, unless the length alone decides it, reads the letter memory and
// compares; the child lookup and its check, the depth update and the
// result follow. A new node longer than one letter adds a second walk.
// The number of link steps is amortized constant over a string.
// in_stall is high while an item is at work. A finished result sits in an
// output register so the next item may enter while it waits. Letters past
// MAX_LEN return an overflow result. After reset a clearing pass zeroes
// the child table, (MAX_LEN + 2) * ALPHABET entries, one entry per cycle,
// with in_stall high. A restart does not clear it: an entry counts only if
// the node it names exists and records that parent and letter.
`default_nettype none

module palindromic_tree_builder_unit #(
	parameter int unsigned MAX_LEN  = 1024,
	parameter int unsigned ALPHABET = 26
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ptb_pkg::in_item_t in_item,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ptb_pkg::out_item_t     out_item
);
	import ptb_pkg::*;

	localparam int unsigned PW  = $clog2(MAX_LEN + 1);
	localparam int unsigned LW  = PW + 1;
	localparam int unsigned ND  = MAX_LEN + 2;
	localparam int unsigned NW  = $clog2(ND);
	localparam int unsigned AW  = $clog2(MAX_LEN);
	localparam int unsigned CD  = ND * ALPHABET;
	localparam int unsigned CW  = $clog2(CD);
	localparam int unsigned NRW = LW + 2 * NW + LetterW + PW;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WRD  = 4'd1;
	localparam logic [3:0] S_WLEN = 4'd2;
	localparam logic [3:0] S_WCMP = 4'd3;
	localparam logic [3:0] S_CRD  = 4'd4;
	localparam logic [3:0] S_CVAL = 4'd5;
	localparam logic [3:0] S_CCHK = 4'd6;
	localparam logic [3:0] S_DRD  = 4'd7;
	localparam logic [3:0] S_DEP  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;
	localparam logic [3:0] S_CLR  = 4'd10;

	logic [3:0]        state_q;
	logic [PW-1:0]     pos_q;
	logic [NW-1:0]     ntot_q;
	logic [NW-1:0]     curn_q;
	logic [TotalW-1:0] total_q;
	logic              out_valid_q;
	logic [CW-1:0]     clr_q;
	out_item_t         out_q;

	logic [LetterW-1:0]        c_q;
	logic [NW-1:0]             v_q;
	logic signed [LW-1:0]      len_q;
	logic [NW-1:0]             link_q;
	logic                      mode_q;
	logic [NW-1:0]             cur_q;
	logic signed [LW-1:0]      cur_len_q;
	logic [NW-1:0]             cur_link_q;
	logic [CW-1:0]             cra_q;
	logic [CW-1:0]             cra0_q;
	logic [NW-1:0]             par_q;
	logic [NW-1:0]             ch_q;
	logic [NW-1:0]             nxt_q;
	logic signed [LW-1:0]      nlen_q;
	logic [NW-1:0]             nlink_q;
	logic [NW-1:0]             npar_q;
	logic [LetterW-1:0]        nlet_q;
	logic                      created_q;
	out_item_t                 res_q;
	logic [NW-1:0]             node_ra_q;

	// memory ports
	logic [NW-1:0]      node_ra;
	logic [NRW-1:0]     node_rd;
	logic [NRW-1:0]     node_wd;
	logic [NW-1:0]      child_rd;
	logic               child_we;
	logic [CW-1:0]      child_wa;
	logic [NW-1:0]      child_wd;
	logic [AW-1:0]      lt_ra;
	logic [LetterW-1:0] lt_rd;
	logic               dep_st;
	logic               clr_st;

	// effective node record, roots are constants
	logic signed [LW-1:0] ne_len;
	logic [NW-1:0]        ne_link;
	logic [NW-1:0]        ne_par;
	logic [LetterW-1:0]   ne_let;
	logic [PW-1:0]        ne_dep;

	logic               in_acc;
	logic [LetterW-1:0] c_in;
	logic               ne_neg;
	logic               wl_short;
	logic               lt_match;
	logic               fnd;
	logic signed [LW-1:0] fnd_len;
	logic [NW-1:0]      fnd_link;
	logic [CW-1:0]      cra_nx;
	logic               ch_ok;
	logic signed [LW-1:0] new_len;
	logic [PW-1:0]      dep;
	logic [TotalW-1:0]  total_nx;
	logic               out_free;

	always_comb begin
		if (node_ra_q == NW'(0)) begin
			ne_len  = -LW'(1);
			ne_link = '0;
			ne_par  = '0;
			ne_let  = '0;
			ne_dep  = '0;
		end else if (node_ra_q == NW'(1)) begin
			ne_len  = '0;
			ne_link = '0;
			ne_par  = '0;
			ne_let  = '0;
			ne_dep  = '0;
		end else begin
			{ne_len, ne_link, ne_par, ne_let, ne_dep} = node_rd;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign c_in     = (32'(in_item.letter) >= ALPHABET) ? LetterW'(ALPHABET - 1)
	                                                     : in_item.letter;

	assign ne_neg   = ne_len < 0;
	assign wl_short = $signed({1'b0, pos_q}) <= ne_len;
	assign lt_ra    = AW'(pos_q - PW'(ne_len) - PW'(1));
	assign lt_match = lt_rd == c_q;
	assign fnd      = (state_q == S_WLEN && ne_neg) || (state_q == S_WCMP && lt_match);
	assign fnd_len  = (state_q == S_WLEN) ? ne_len : len_q;
	assign fnd_link = (state_q == S_WLEN) ? ne_link : link_q;
	assign cra_nx   = CW'(v_q) * CW'(ALPHABET) + CW'(c_q);

	// stale child entries from an earlier string fail this check
	assign ch_ok    = (ch_q >= NW'(2)) && (ch_q <= ntot_q) && (ne_par == par_q)
	                  && (ne_let == c_q);
	assign new_len  = cur_len_q + LW'(2);
	assign dep      = ne_dep + PW'(1);
	assign total_nx = total_q + TotalW'(dep);
	assign out_free = !out_valid_q || !out_stall;
	assign dep_st   = state_q == S_DEP;
	assign clr_st   = state_q == S_CLR;

	assign child_we = clr_st || (dep_st && created_q);
	assign child_wa = clr_st ? clr_q : cra0_q;
	assign child_wd = clr_st ? '0 : nxt_q;

	always_comb begin
		case (state_q)
			S_CVAL:  node_ra = child_rd;
			S_DRD:   node_ra = nlink_q;
			default: node_ra = v_q;
		endcase
	end

	assign node_wd = {nlen_q, nlink_q, npar_q, nlet_q, dep};

	ptb_ram #(.WIDTH(NRW), .DEPTH(ND)) u_node_mem (
		.clk   (clk),
		.we    (dep_st),
		.waddr (nxt_q),
		.wdata (node_wd),
		.raddr (node_ra),
		.rdata (node_rd)
	);

	ptb_ram #(.WIDTH(NW), .DEPTH(CD)) u_child_mem (
		.clk   (clk),
		.we    (child_we),
		.waddr (child_wa),
		.wdata (child_wd),
		.raddr (cra_q),
		.rdata (child_rd)
	);

	ptb_ram #(.WIDTH(LetterW), .DEPTH(MAX_LEN)) u_letter_mem (
		.clk   (clk),
		.we    (dep_st),
		.waddr (pos_q[AW-1:0]),
		.wdata (c_q),
		.raddr (lt_ra),
		.rdata (lt_rd)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			pos_q       <= '0;
			ntot_q      <= NW'(1);
			curn_q      <= NW'(1);
			total_q     <= '0;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CD - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						if (in_item.restart) begin
							pos_q   <= '0;
							ntot_q  <= NW'(1);
							curn_q  <= NW'(1);
							total_q <= '0;
							state_q <= S_WRD;
						end else if (32'(pos_q) >= MAX_LEN) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_WRD;
						end
					end
				end
				S_WRD:  state_q <= S_WLEN;
				S_WLEN: begin
					if (ne_neg) begin
						state_q <= S_CRD;
					end else if (wl_short) begin
						state_q <= S_WRD;
					end else begin
						state_q <= S_WCMP;
					end
				end
				S_WCMP: state_q <= lt_match ? S_CRD : S_WRD;
				S_CRD:  state_q <= S_CVAL;
				S_CVAL: state_q <= S_CCHK;
				S_CCHK: begin
					if (!mode_q && !ch_ok && new_len != LW'(1)) begin
						state_q <= S_WRD;
					end else begin
						state_q <= S_DRD;
					end
				end
				S_DRD:  state_q <= S_DEP;
				S_DEP: begin
					pos_q   <= pos_q + PW'(1);
					curn_q  <= nxt_q;
					total_q <= total_nx;
					if (created_q) begin
						ntot_q <= nxt_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		node_ra_q <= node_ra;
		if (fnd) begin
			cra_q <= cra_nx;
			par_q <= v_q;
			if (!mode_q) begin
				cur_q      <= v_q;
				cur_len_q  <= fnd_len;
				cur_link_q <= fnd_link;
				cra0_q     <= cra_nx;
			end
		end
		case (state_q)
			S_IDLE: begin
				c_q    <= c_in;
				v_q    <= in_item.restart ? NW'(1) : curn_q;
				mode_q <= 1'b0;
				res_q  <= '{suffix_pal_count: '0, longest_suffix_len: '0,
				           distinct_count: CountW'(ntot_q - NW'(1)),
				           total_count: total_q, is_new: 1'b0, overflow: 1'b1};
			end
			S_WLEN: begin
				len_q  <= ne_len;
				link_q <= ne_link;
				if (!ne_neg && wl_short) begin
					v_q <= ne_link;
				end
			end
			S_WCMP: begin
				if (!lt_match) begin
					v_q <= link_q;
				end
			end
			S_CVAL: ch_q <= child_rd;
			S_CCHK: begin
				if (mode_q) begin
					nlink_q <= ch_ok ? ch_q : '0;
				end else if (ch_ok) begin
					nxt_q     <= ch_q;
					nlen_q    <= ne_len;
					nlink_q   <= ne_link;
					npar_q    <= ne_par;
					nlet_q    <= ne_let;
					created_q <= 1'b0;
				end else begin
					nxt_q     <= ntot_q + NW'(1);
					nlen_q    <= new_len;
					npar_q    <= cur_q;
					nlet_q    <= c_q;
					created_q <= 1'b1;
					if (new_len == LW'(1)) begin
						nlink_q <= NW'(1);
					end else begin
						mode_q <= 1'b1;
						v_q    <= cur_link_q;
					end
				end
			end
			S_DEP: begin
				res_q <= '{suffix_pal_count: CountW'(dep),
				           longest_suffix_len: CountW'(nlen_q),
				           distinct_count: CountW'((created_q ? nxt_q : ntot_q) - NW'(1)),
				           total_count: total_nx, is_new: created_q, overflow: 1'b0};
			end
			S_FIN: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= MAX_LEN)
		else $error("position past MAX_LEN");

	a_nodes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ntot_q) <= 32'(pos_q) + 1)
		else $error("more nodes than letters");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted item not started");

	a_new_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEP && created_q) |-> nxt_q == ntot_q + NW'(1))
		else $error("new node index not next free");

endmodule

`default_nettype wire
